// File: rtl/bezier_segment_sampler_macros.svh
// assertion macros for the bezier segment sampler
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BEZIER_SEGMENT_SAMPLER_MACROS_SVH
`define BEZIER_SEGMENT_SAMPLER_MACROS_SVH

// same-cycle implication
`define BSS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("bezier segment sampler check failed");

// next-cycle implication
`define BSS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("bezier segment sampler check failed");

`endif

// File: rtl/bss_pkg.sv
// shared types, codes and step tables of the bezier segment sampler
// no dependencies
`default_nettype none

package bss_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned TW     = 16;
  localparam int unsigned WgtW   = 49;

  localparam logic [CfgW-1:0] CfgReset = 7'd64;

  // segment kinds
  localparam logic [1:0] OpCorner = 2'd0;
  localparam logic [1:0] OpQuad   = 2'd1;
  localparam logic [1:0] OpCubic  = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] ctrl1_x;
    logic signed [CoordW-1:0] ctrl1_y;
    logic signed [CoordW-1:0] ctrl2_x;
    logic signed [CoordW-1:0] ctrl2_y;
  } seg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last;
  } pt_t;

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            issue;
    logic            last;
    logic [CfgW-1:0] n;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adv;
    logic busy;
  } st_t;

  // t step for n samples: 65536 / n and 65536 % n, indexed by n - 1
  localparam logic [TW-1:0] StepQuot [64] = '{
    16'(65536 / 1),  16'(65536 / 2),  16'(65536 / 3),  16'(65536 / 4),
    16'(65536 / 5),  16'(65536 / 6),  16'(65536 / 7),  16'(65536 / 8),
    16'(65536 / 9),  16'(65536 / 10), 16'(65536 / 11), 16'(65536 / 12),
    16'(65536 / 13), 16'(65536 / 14), 16'(65536 / 15), 16'(65536 / 16),
    16'(65536 / 17), 16'(65536 / 18), 16'(65536 / 19), 16'(65536 / 20),
    16'(65536 / 21), 16'(65536 / 22), 16'(65536 / 23), 16'(65536 / 24),
    16'(65536 / 25), 16'(65536 / 26), 16'(65536 / 27), 16'(65536 / 28),
    16'(65536 / 29), 16'(65536 / 30), 16'(65536 / 31), 16'(65536 / 32),
    16'(65536 / 33), 16'(65536 / 34), 16'(65536 / 35), 16'(65536 / 36),
    16'(65536 / 37), 16'(65536 / 38), 16'(65536 / 39), 16'(65536 / 40),
    16'(65536 / 41), 16'(65536 / 42), 16'(65536 / 43), 16'(65536 / 44),
    16'(65536 / 45), 16'(65536 / 46), 16'(65536 / 47), 16'(65536 / 48),
    16'(65536 / 49), 16'(65536 / 50), 16'(65536 / 51), 16'(65536 / 52),
    16'(65536 / 53), 16'(65536 / 54), 16'(65536 / 55), 16'(65536 / 56),
    16'(65536 / 57), 16'(65536 / 58), 16'(65536 / 59), 16'(65536 / 60),
    16'(65536 / 61), 16'(65536 / 62), 16'(65536 / 63), 16'(65536 / 64)
  };

  localparam logic [5:0] StepRem [64] = '{
    6'(65536 % 1),  6'(65536 % 2),  6'(65536 % 3),  6'(65536 % 4),
    6'(65536 % 5),  6'(65536 % 6),  6'(65536 % 7),  6'(65536 % 8),
    6'(65536 % 9),  6'(65536 % 10), 6'(65536 % 11), 6'(65536 % 12),
    6'(65536 % 13), 6'(65536 % 14), 6'(65536 % 15), 6'(65536 % 16),
    6'(65536 % 17), 6'(65536 % 18), 6'(65536 % 19), 6'(65536 % 20),
    6'(65536 % 21), 6'(65536 % 22), 6'(65536 % 23), 6'(65536 % 24),
    6'(65536 % 25), 6'(65536 % 26), 6'(65536 % 27), 6'(65536 % 28),
    6'(65536 % 29), 6'(65536 % 30), 6'(65536 % 31), 6'(65536 % 32),
    6'(65536 % 33), 6'(65536 % 34), 6'(65536 % 35), 6'(65536 % 36),
    6'(65536 % 37), 6'(65536 % 38), 6'(65536 % 39), 6'(65536 % 40),
    6'(65536 % 41), 6'(65536 % 42), 6'(65536 % 43), 6'(65536 % 44),
    6'(65536 % 45), 6'(65536 % 46), 6'(65536 % 47), 6'(65536 % 48),
    6'(65536 % 49), 6'(65536 % 50), 6'(65536 % 51), 6'(65536 % 52),
    6'(65536 % 53), 6'(65536 % 54), 6'(65536 % 55), 6'(65536 % 56),
    6'(65536 % 57), 6'(65536 % 58), 6'(65536 % 59), 6'(65536 % 60),
    6'(65536 % 61), 6'(65536 % 62), 6'(65536 % 63), 6'(65536 % 64)
  };

endpackage

`default_nettype wire

// File: rtl/bss_ctrl.sv
// sequencing controller: config register, segment accept, sample issue, drain
// depends on bss_pkg
`default_nettype none

module bss_ctrl #(
  parameter int unsigned MaxSamples = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [bss_pkg::CfgW-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_op_i,
  output logic                  in_stall_o,
  input  bss_pkg::st_t          status_i,
  output bss_pkg::cmd_t         cmd_o
);
  import bss_pkg::*;

  localparam int unsigned CntW = $clog2(MaxSamples + 1);
  localparam logic [CfgW-1:0] MaxN = CfgW'(MaxSamples);

  typedef enum logic [1:0] {
    StIdle,
    StIssue,
    StDrain
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] n_q;
  logic [CfgW-1:0] cfg_q;
  logic [CfgW-1:0] n_eff;
  logic [CfgW-1:0] n_sel;
  logic            is_curve;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);

  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CfgW'(1);
    end else if (cfg_q > MaxN) begin
      n_eff = MaxN;
    end else begin
      n_eff = cfg_q;
    end
  end

  assign is_curve = (in_op_i == OpQuad) || (in_op_i == OpCubic);
  // a corner is a single forced sample
  assign n_sel    = is_curve ? n_eff : CfgW'(1);

  always_comb begin
    cmd_o.load  = (state_q == StIdle) && in_valid_i;
    cmd_o.issue = (state_q == StIssue) && status_i.adv;
    cmd_o.last  = (cnt_q == n_q - CntW'(1));
    cmd_o.n     = n_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      n_q     <= '0;
      cfg_q   <= CfgReset;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            cnt_q   <= '0;
            n_q     <= CntW'(n_sel);
            state_q <= StIssue;
          end
        end
        StIssue: begin
          if (status_i.adv) begin
            cnt_q <= cnt_q + CntW'(1);
            if (cnt_q == n_q - CntW'(1)) begin
              state_q <= StDrain;
            end
          end
        end
        StDrain: begin
          if (!status_i.busy) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/bss_dp.sv
// sampling datapath: t stepper, weight pipeline, weighted sum, output register
// depends on bss_pkg
`default_nettype none

module bss_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bss_pkg::cmd_t cmd_i,
  input  bss_pkg::seg_t in_data_i,
  output bss_pkg::st_t  status_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bss_pkg::pt_t  out_data_o
);
  import bss_pkg::*;

  localparam logic [CoordW-1:0] SignFlip  = 16'h8000;
  localparam logic [64:0]       RoundBias = 65'h0_8000_0000_0000;

  // segment registers, coordinates in offset binary
  logic [1:0]        mode_q;
  logic [CoordW-1:0] px_q [4];
  logic [CoordW-1:0] py_q [4];

  // t stepper
  logic [TW-1:0]   t_q;
  logic [TW-1:0]   quot_q;
  logic [5:0]      rem_q;
  logic [5:0]      rstep_q;
  logic [CfgW-1:0] n_q;
  logic [5:0]      nidx;
  logic [6:0]      rem_sum;
  logic            wrap;

  // stage 1
  logic        v1_q;
  logic        last1_q;
  logic [16:0] u_d;
  logic [16:0] u1_q;
  logic [18:0] u3_q;
  logic [TW-1:0] t1_q;
  logic [33:0] uu_d, uu_q;
  logic [32:0] ut_d, ut_q;
  logic [31:0] tt_d, tt_q;

  // stage 2
  logic            v2_q;
  logic            last2_q;
  logic [50:0]     mul0;
  logic [51:0]     mul1;
  logic [50:0]     mul2;
  logic [47:0]     mul3;
  logic [WgtW-1:0] w_d [4];
  logic [WgtW-1:0] w_q [4];

  // stage 3
  logic        v3_q;
  logic        last3_q;
  logic [64:0] mx [4];
  logic [64:0] my [4];
  logic [63:0] prx_q [4];
  logic [63:0] pry_q [4];

  // output
  logic        out_valid_q;
  pt_t         out_q;
  logic [64:0] sumx, sumy;
  logic [CoordW-1:0] rx, ry;
  logic        adv;

  assign adv             = !(out_valid_q && out_stall_i);
  assign status_o.adv    = adv;
  assign status_o.busy   = v1_q || v2_q || v3_q;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  // t stepper: t = floor((i * 65536 + n/2) / n), tracked by quotient and remainder
  assign nidx    = 6'(cmd_i.n - CfgW'(1));
  assign rem_sum = {1'b0, rem_q} + {1'b0, rstep_q};
  assign wrap    = (rem_sum >= n_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= in_data_i.op;
      px_q[0] <= in_data_i.start_x ^ SignFlip;
      px_q[1] <= in_data_i.ctrl1_x ^ SignFlip;
      px_q[2] <= in_data_i.ctrl2_x ^ SignFlip;
      px_q[3] <= in_data_i.end_x   ^ SignFlip;
      py_q[0] <= in_data_i.start_y ^ SignFlip;
      py_q[1] <= in_data_i.ctrl1_y ^ SignFlip;
      py_q[2] <= in_data_i.ctrl2_y ^ SignFlip;
      py_q[3] <= in_data_i.end_y   ^ SignFlip;
      t_q     <= '0;
      rem_q   <= 6'(cmd_i.n >> 1);
      quot_q  <= StepQuot[nidx];
      rstep_q <= StepRem[nidx];
      n_q     <= cmd_i.n;
    end else if (cmd_i.issue) begin
      t_q   <= t_q + quot_q + TW'(wrap);
      rem_q <= wrap ? 6'(rem_sum - n_q) : rem_sum[5:0];
    end
  end

  // stage 1: squares and cross term
  assign u_d  = 17'h1_0000 - {1'b0, t_q};
  assign uu_d = u_d * u_d;
  assign ut_d = u_d * t_q;
  assign tt_d = t_q * t_q;

  // stage 2: bernstein weights scaled to 2^48
  assign mul0 = uu_q * u1_q;
  assign mul1 = u3_q * ut_q;
  assign mul2 = u3_q * tt_q;
  assign mul3 = tt_q * t1_q;

  always_comb begin
    case (mode_q)
      OpCubic: begin
        w_d[0] = mul0[WgtW-1:0];
        w_d[1] = mul1[WgtW-1:0];
        w_d[2] = mul2[WgtW-1:0];
        w_d[3] = {1'b0, mul3};
      end
      OpQuad: begin
        // quadratic weights times u + t = 2^16
        w_d[0] = {uu_q[32:0], 16'b0};
        w_d[1] = {ut_q[31:0], 17'b0};
        w_d[2] = '0;
        w_d[3] = {1'b0, tt_q, 16'b0};
      end
      default: begin
        // corner: full weight on the end point
        w_d[0] = '0;
        w_d[1] = '0;
        w_d[2] = '0;
        w_d[3] = {1'b1, 48'b0};
      end
    endcase
  end

  // stage 3: weight times coordinate
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mx[k] = w_q[k] * px_q[k];
      my[k] = w_q[k] * py_q[k];
    end
  end

  // output: sum, round, saturate, back to two's complement
  assign sumx = {1'b0, prx_q[0]} + {1'b0, prx_q[1]} + {1'b0, prx_q[2]}
              + {1'b0, prx_q[3]} + RoundBias;
  assign sumy = {1'b0, pry_q[0]} + {1'b0, pry_q[1]} + {1'b0, pry_q[2]}
              + {1'b0, pry_q[3]} + RoundBias;
  assign rx   = (sumx[64] ? 16'hFFFF : sumx[63:48]) ^ SignFlip;
  assign ry   = (sumy[64] ? 16'hFFFF : sumy[63:48]) ^ SignFlip;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u1_q    <= u_d;
      u3_q    <= {2'b0, u_d} + {1'b0, u_d, 1'b0};
      t1_q    <= t_q;
      uu_q    <= uu_d;
      ut_q    <= ut_d;
      tt_q    <= tt_d;
      last1_q <= cmd_i.last;
      w_q     <= w_d;
      last2_q <= last1_q;
      for (int k = 0; k < 4; k++) begin
        prx_q[k] <= mx[k][63:0];
        pry_q[k] <= my[k][63:0];
      end
      last3_q       <= last2_q;
      out_q.point_x <= rx;
      out_q.point_y <= ry;
      out_q.last    <= last3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bezier_segment_sampler.sv
// bezier segment sampler top level: controller plus sampling datapath
// depends on bss_pkg, bss_ctrl, bss_dp and bezier_segment_sampler_macros.svh
//
//  channel | direction | handshake              | carries
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o   | one seg_t path segment request
//  out     | output    | out_valid_o / out_stall_i | one pt_t sampled point
//  cfg     | input     | cfg_valid_i / cfg_ready_o | samples_per_curve, 7 bits
//
// a curve segment yields N points with N the sample count, a corner one point;
// one point leaves per cycle from the four-stage sampling pipeline unless stalled
// rst_ni clears the controller, pipeline valids and sets N to 64
// a stall on the output freezes the whole pipeline; a new segment is taken
// only once the previous one has left the stages before the output register
`default_nettype none

`include "bezier_segment_sampler_macros.svh"

module bezier_segment_sampler #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // segment requests
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  bss_pkg::seg_t            in_data_i,
  // sampled points
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output bss_pkg::pt_t             out_data_o,
  // sample count register
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bss_pkg::CfgW-1:0] cfg_data_i
);
  import bss_pkg::*;

  // command and status between the controller and the datapath
  cmd_t cmd;
  st_t  st;

  // controller: owns the sample count register and walks the samples
  bss_ctrl #(
    .MaxSamples (MAX_SAMPLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .in_stall_o  (in_stall_o),
    .status_i    (st),
    .cmd_o       (cmd)
  );

  // datapath: t stepping, weights, weighted sum and the output register
  bss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .status_o    (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a taken segment blocks the input until it is finished
  `BSS_ASSERT_NEXT(a_accept_blocks, in_valid_i && !in_stall_o, in_stall_o)
  // the stages before the output register are empty whenever a new segment can be taken
  `BSS_ASSERT_IMP(a_idle_empty, !in_stall_o, !st.busy)
  // no sample is issued right after the final one of a segment
  `BSS_ASSERT_NEXT(a_last_ends, cmd.issue && cmd.last, !cmd.issue)

endmodule

`default_nettype wire
